@@ hdl/dpl_pkg.sv @@
// Package for the double-byte printable-length block: widths, codes,
// queue command type and byte classification helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpl_pkg;

  localparam int BYTE_W     = 8;
  localparam int LETTER_W   = 16;
  localparam int LANG_W     = 4;
  localparam int LEN_W      = 11;
  localparam int MAX_LENGTH = 1024;
  localparam int LEN_CAP    = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LEN_LIMIT =
    LEN_W'((MAX_LENGTH > LEN_CAP) ? LEN_CAP : MAX_LENGTH);

  // Command queue between decoder and result stage
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Language register codes
  localparam logic [LANG_W-1:0] LANG_KOREAN = LANG_W'(10);
  localparam logic [LANG_W-1:0] LANG_SJIS   = LANG_W'(11);

  // Special byte values
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_COL_LO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_COL_HI = 8'h40;

  // One queued command: an optional letter result and an optional end result
  typedef struct packed {
    logic                has_letter;
    logic [LETTER_W-1:0] letter_code;
    logic                trailing_punct;
    logic                counted;
    logic                colour_code;
    logic                has_end;
  } dpl_cmd_t;

  // Decoder push toward the queue
  typedef struct packed {
    logic     valid;
    dpl_cmd_t cmd;
  } dpl_push_t;

  // Queue head toward the result stage
  typedef struct packed {
    logic     valid;
    dpl_cmd_t cmd;
  } dpl_head_t;

  function automatic logic korean_pair(input logic [BYTE_W-1:0] hi,
                                       input logic [BYTE_W-1:0] lo);
    return (hi >= 8'hB0) && (hi <= 8'hC8) && (lo > 8'hA0) && (lo != 8'hFF);
  endfunction

  function automatic logic sjis_pair(input logic [BYTE_W-1:0] hi,
                                     input logic [BYTE_W-1:0] lo);
    logic lead;
    logic trail;
    lead  = ((hi >= 8'h81) && (hi <= 8'h9F)) || ((hi >= 8'hE0) && (hi <= 8'hEF));
    trail = ((lo >= 8'h40) && (lo <= 8'h7E)) || ((lo >= 8'h80) && (lo <= 8'hFC));
    return lead && trail;
  endfunction

  function automatic logic single_punct(input logic [BYTE_W-1:0] c);
    return (c == 8'h21) || (c == 8'h3F) || (c == 8'h2C) ||
           (c == 8'h2E) || (c == 8'h3B) || (c == 8'h3A);
  endfunction

  // Shift-JIS full-width punctuation range 8140..8151
  function automatic logic sjis_punct(input logic [LETTER_W-1:0] code);
    return (code >= 16'h8140) && (code < 16'h8152);
  endfunction

endpackage

`default_nettype wire

@@ hdl/dpl_if.sv @@
// Valid/ready channel interfaces for the text byte input and the result output.
// Depends on dpl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dpl_byte_if;
  logic                        valid;
  logic                        ready;
  logic [dpl_pkg::BYTE_W-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface dpl_result_if;
  logic                         valid;
  logic                         ready;
  logic [dpl_pkg::LETTER_W-1:0] letter_code;
  logic                         trailing_punct;
  logic                         counted;
  logic                         colour_code;
  logic [dpl_pkg::LEN_W-1:0]    printed_length;
  logic                         end_of_string;

  modport source (output valid, output letter_code, output trailing_punct,
                  output counted, output colour_code, output printed_length,
                  output end_of_string, input ready);
  modport sink   (input valid, input letter_code, input trailing_punct,
                  input counted, input colour_code, input printed_length,
                  input end_of_string, output ready);
endinterface

`default_nettype wire

@@ hdl/dpl_front.sv @@
// Decoder front end: accepts text bytes, keeps one byte of lookahead and
// the language register, and pushes letter/end commands. Uses dpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpl_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dpl_byte_if.sink                   text_i,
  input  logic                       cfg_we_i,
  input  logic [dpl_pkg::LANG_W-1:0] cfg_data_i,
  input  logic                       queue_full_i,
  output dpl_pkg::dpl_push_t         push_o
);
  import dpl_pkg::*;

  logic [LANG_W-1:0] lang_q;
  logic [BYTE_W-1:0] held_q, held_d;
  logic              held_valid_q, held_valid_d;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic              kor_hit, sj_hit, pair, colour, single, is_end;
  logic [LETTER_W-1:0] pair_code;

  assign b             = text_i.text_byte;
  assign text_i.ready  = !queue_full_i;
  assign accept        = text_i.valid && text_i.ready;

  // Classify the held byte against the incoming one
  always_comb begin
    pair_code = {held_q, b};
    kor_hit   = (lang_q == LANG_KOREAN) && korean_pair(held_q, b);
    sj_hit    = (lang_q == LANG_SJIS) && sjis_pair(held_q, b);
    pair      = held_valid_q && (kor_hit || sj_hit);
    colour    = held_valid_q && !pair && (held_q == CH_CARET) &&
                (b >= CH_COL_LO) && (b <= CH_COL_HI);
    single    = held_valid_q && !pair && !colour;
    is_end    = (b == CH_NUL) && !pair && !colour;
  end

  // Build the command for this transfer
  always_comb begin
    push_o.cmd.has_letter     = pair || colour || single;
    push_o.cmd.letter_code    = pair ? pair_code : {{(LETTER_W-BYTE_W){1'b0}}, held_q};
    push_o.cmd.trailing_punct = pair ? (sj_hit && sjis_punct(pair_code))
                                     : (single && single_punct(held_q));
    push_o.cmd.counted        = pair || (single && (held_q != CH_LF) && (held_q != CH_CR));
    push_o.cmd.colour_code    = colour;
    push_o.cmd.has_end        = is_end;
    push_o.valid              = accept && (pair || colour || single || is_end);
  end

  // Lookahead update
  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    if (accept) begin
      if (pair || colour || (b == CH_NUL)) begin
        held_d       = CH_NUL;
        held_valid_d = 1'b0;
      end else begin
        held_d       = b;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lang_q       <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lang_q <= cfg_data_i;
      end
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // An empty lookahead always reads as zero
  a_held_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_valid_q |-> (held_q == CH_NUL))
    else $error("held byte not cleared");
  // A zero byte always leaves the lookahead empty
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (b == CH_NUL)) |=> !held_valid_q)
    else $error("lookahead kept after end of string");
`endif

endmodule

`default_nettype wire

@@ hdl/dpl_queue.sv @@
// Short command queue between decoder and result stage.
// Register-based circular buffer; uses dpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpl_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpl_pkg::dpl_push_t push_i,
  output logic               full_o,
  output dpl_pkg::dpl_head_t head_o,
  input  logic               pop_i
);
  import dpl_pkg::*;

  dpl_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_q];

  // Pointer wrap at the queue depth
  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      unique case ({push_i.valid, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !head_o.valid))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ hdl/dpl_back.sv @@
// Result stage: takes queued commands, keeps the running printed length and
// drives the registered result channel. Uses dpl_pkg and dpl_result_if.
`timescale 1ns / 1ps
`default_nettype none

module dpl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dpl_pkg::dpl_head_t head_i,
  output logic               pop_o,
  dpl_result_if.source       result_o
);
  import dpl_pkg::*;

  logic [LEN_W-1:0]    len_q, len_d, len_inc;
  logic                phase_q, phase_d;
  logic                out_valid_q, out_valid_d;
  logic [LETTER_W-1:0] letter_q, letter_d;
  logic                punct_q, punct_d, counted_q, counted_d, colour_q, colour_d;
  logic [LEN_W-1:0]    plen_q, plen_d;
  logic                eos_q, eos_d;

  logic load, emit_letter, emit_end;

  // Output register free or being drained
  assign load        = head_i.valid && (!out_valid_q || result_o.ready);
  assign emit_letter = head_i.cmd.has_letter && !phase_q;
  assign emit_end    = !emit_letter;
  assign pop_o       = load && (emit_end || !head_i.cmd.has_end);
  assign len_inc     = (len_q < LEN_LIMIT) ? len_q + LEN_W'(1) : len_q;

  // Next result and running length
  always_comb begin
    len_d       = len_q;
    phase_d     = phase_q;
    letter_d    = letter_q;
    punct_d     = punct_q;
    counted_d   = counted_q;
    colour_d    = colour_q;
    plen_d      = plen_q;
    eos_d       = eos_q;
    out_valid_d = out_valid_q && !result_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
      if (emit_letter) begin
        if (head_i.cmd.counted) begin
          len_d = len_inc;
        end
        phase_d   = head_i.cmd.has_end;
        letter_d  = head_i.cmd.letter_code;
        punct_d   = head_i.cmd.trailing_punct;
        counted_d = head_i.cmd.counted;
        colour_d  = head_i.cmd.colour_code;
        plen_d    = head_i.cmd.counted ? len_inc : len_q;
        eos_d     = 1'b0;
      end else begin
        len_d     = '0;
        phase_d   = 1'b0;
        letter_d  = '0;
        punct_d   = 1'b0;
        counted_d = 1'b0;
        colour_d  = 1'b0;
        plen_d    = len_q;
        eos_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    letter_q  <= letter_d;
    punct_q   <= punct_d;
    counted_q <= counted_d;
    colour_q  <= colour_d;
    plen_q    <= plen_d;
    eos_q     <= eos_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.letter_code    = letter_q;
  assign result_o.trailing_punct = punct_q;
  assign result_o.counted        = counted_q;
  assign result_o.colour_code    = colour_q;
  assign result_o.printed_length = plen_q;
  assign result_o.end_of_string  = eos_q;

`ifndef NO_ASSERTIONS
  a_len_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_LIMIT)
    else $error("length above limit");
  a_phase_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_i.valid && head_i.cmd.has_end))
    else $error("pending end result without queued command");
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && emit_end) |=> (len_q == '0))
    else $error("length not cleared after end of string");
`endif

endmodule

`default_nettype wire

@@ hdl/dbcs_printable_length_top.sv @@
// Top level of the double-byte printable-length block.
// Instantiates dpl_front, dpl_queue and dpl_back; uses dpl_pkg and dpl_if.
//
//   Port         Dir  Kind          Payload
//   text_i       in   valid/ready   text_byte[7:0]
//   result_o     out  valid/ready   letter_code, flags, printed_length, end_of_string
//   cfg_we_i     in   write strobe  cfg_data_i[3:0] -> language register
//
// One byte is taken per cycle while the command queue is not full; a byte
// that yields a letter plus end of string gives two results in turn through
// the single result register in dpl_back. Commands pass through the queue into it.
// The two-entry command queue lets input and output stall independently.
// Asynchronous active-low reset clears lookahead, length, queue and register.
`timescale 1ns / 1ps
`default_nettype none

module dbcs_printable_length_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dpl_byte_if.sink                   text_i,
  dpl_result_if.source               result_o,
  input  logic                       cfg_we_i,
  input  logic [dpl_pkg::LANG_W-1:0] cfg_data_i
);
  import dpl_pkg::*;

  dpl_push_t push;
  dpl_head_t head;
  logic      queue_full;
  logic      pop;

  dpl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  dpl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  dpl_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
